// File: rtl/tre_pkg.sv
// Package for the reprojection error pipeline: widths, register indexes and divider step.
package tre_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int FIELD_W     = 32;
    localparam int LIN_W       = 66;   // exact sum of two Q.28 products and an offset
    localparam int MAG_W       = 64;   // magnitude of a linear sum
    localparam int Q_W         = 50;   // quotient bits kept; larger quotients saturate
    localparam int NLO_W       = 22;   // numerator bits below the initial remainder
    localparam int DIV_ST      = Q_W;  // one quotient bit per stage
    localparam int SQ_HALF     = 24;
    localparam int SQ_MAG_W    = 2 * SQ_HALF;
    localparam int SQ_W        = 2 * SQ_MAG_W + 1;
    localparam int SUM_W       = SQ_W + 1;
    localparam int LATENCY     = DIV_ST + 9;
    localparam int CFG_IDX_W   = 3;

    localparam logic [CFG_IDX_W-1:0] REG_MODEL_KIND  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_PAIR_A = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_PAIR_B = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_PAIR_C = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_PAIR_D = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_LAST   = 3'd5;

    localparam logic [FIELD_W-1:0] COEF_ONE = 32'h0001_0000;

    // one lane of the restoring divider
    typedef struct packed {
        logic [MAG_W-1:0] rem;
        logic [MAG_W-1:0] den;
        logic [Q_W-1:0]   nn;
        logic [Q_W-1:0]   quo;
        logic             neg;
    } t_lane;

    // item data carried alongside the divider
    typedef struct packed {
        logic                    valid;
        logic                    dz;
        logic                    ovf_x;
        logic                    ovf_y;
        logic signed [LIN_W-1:0] px;
        logic signed [LIN_W-1:0] py;
        logic signed [FIELD_W-1:0] tx;
        logic signed [FIELD_W-1:0] ty;
    } t_side;

    // sign extend a coordinate from its low COORD_WIDTH bits
    function automatic logic signed [FIELD_W-1:0] sext_coord(input logic [FIELD_W-1:0] v);
        logic signed [FIELD_W-1:0] t;
        t = $signed(v << (FIELD_W - COORD_WIDTH));
        return t >>> (FIELD_W - COORD_WIDTH);
    endfunction

    // bring in one numerator bit, subtract the divisor where it fits
    function automatic t_lane div_step(input t_lane a);
        t_lane       b;
        logic [MAG_W:0] t;
        b = a;
        t = {a.rem, a.nn[Q_W-1]};
        b.nn = {a.nn[Q_W-2:0], 1'b0};
        if (t >= {1'b0, a.den}) begin
            t = t - {1'b0, a.den};
            b.quo = {a.quo[Q_W-2:0], 1'b1};
        end else begin
            b.quo = {a.quo[Q_W-2:0], 1'b0};
        end
        b.rem = t[MAG_W-1:0];
        return b;
    endfunction

endpackage

// File: rtl/transform_reprojection_error_top.sv
// Top level: pipelined squared reprojection error of point pairs under a 3x3 model.
//
//  channel   | handshake                  | payload
//  ----------+----------------------------+------------------------------------------
//  command   | i_start / o_busy           | i_src_x i_src_y i_dst_x i_dst_y
//  result    | o_done strobe, one cycle   | o_sq_error o_denom_zero
//  config    | i_cfg_valid / o_cfg_ready  | i_cfg_index i_cfg_data
//
// One transaction per cycle; each result passes through the 50-stage restoring divider
// (one quotient bit per stage) and the multiply, sum, magnitude, error and square
// stages around it.
// Reset clears the configuration (the last coefficient is set to one) and every valid bit; o_busy stays low.
// The receiver cannot stall, so the pipeline advances every cycle.
module transform_reprojection_error_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic signed [31:0] i_src_x,
    input  logic signed [31:0] i_src_y,
    input  logic signed [31:0] i_dst_x,
    input  logic signed [31:0] i_dst_y,
    output logic        o_done,
    output logic [63:0] o_sq_error,
    output logic        o_denom_zero,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [tre_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    localparam int LW = tre_pkg::LIN_W;
    localparam int MW = tre_pkg::MAG_W;
    localparam int FW = tre_pkg::FIELD_W;
    localparam int QW = tre_pkg::Q_W;
    localparam int DS = tre_pkg::DIV_ST;
    localparam int HW = tre_pkg::SQ_HALF;
    localparam int SMW = tre_pkg::SQ_MAG_W;

    // configuration registers
    logic        r_model_kind;
    logic [63:0] r_coef_a, r_coef_b, r_coef_c, r_coef_d;
    logic [31:0] r_coef_last;

    assign o_cfg_ready = 1'b1;
    assign o_busy      = 1'b0;

    // take a configuration transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_model_kind <= 1'b0;
            r_coef_a     <= '0;
            r_coef_b     <= '0;
            r_coef_c     <= '0;
            r_coef_d     <= '0;
            r_coef_last  <= tre_pkg::COEF_ONE;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                tre_pkg::REG_MODEL_KIND:  r_model_kind <= i_cfg_data[0];
                tre_pkg::REG_COEF_PAIR_A: r_coef_a     <= i_cfg_data;
                tre_pkg::REG_COEF_PAIR_B: r_coef_b     <= i_cfg_data;
                tre_pkg::REG_COEF_PAIR_C: r_coef_c     <= i_cfg_data;
                tre_pkg::REG_COEF_PAIR_D: r_coef_d     <= i_cfg_data;
                tre_pkg::REG_COEF_LAST:   r_coef_last  <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    logic signed [FW-1:0] m0, m1, m2, m3, m4, m5, m6, m7, m8;
    assign m0 = $signed(r_coef_a[31:0]);
    assign m1 = $signed(r_coef_a[63:32]);
    assign m2 = $signed(r_coef_b[31:0]);
    assign m3 = $signed(r_coef_b[63:32]);
    assign m4 = $signed(r_coef_c[31:0]);
    assign m5 = $signed(r_coef_c[63:32]);
    assign m6 = $signed(r_coef_d[31:0]);
    assign m7 = $signed(r_coef_d[63:32]);
    assign m8 = $signed(r_coef_last);

    // stage 1: coefficient products
    logic signed [FW-1:0] x_in, y_in;
    assign x_in = tre_pkg::sext_coord(i_src_x);
    assign y_in = tre_pkg::sext_coord(i_src_y);

    logic                 r_s1_valid;
    logic signed [63:0]   r_s1_p0, r_s1_p1, r_s1_p3, r_s1_p4, r_s1_p6, r_s1_p7;
    logic signed [FW-1:0] r_s1_tx, r_s1_ty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_s1_valid <= 1'b0;
        else          r_s1_valid <= i_start && !o_busy;
        r_s1_p0 <= m0 * x_in;
        r_s1_p1 <= m1 * y_in;
        r_s1_p3 <= m3 * x_in;
        r_s1_p4 <= m4 * y_in;
        r_s1_p6 <= m6 * x_in;
        r_s1_p7 <= m7 * y_in;
        r_s1_tx <= tre_pkg::sext_coord(i_dst_x);
        r_s1_ty <= tre_pkg::sext_coord(i_dst_y);
    end

    // stage 2: linear sums in Q.28
    logic                 r_s2_valid;
    logic signed [LW-1:0] r_s2_px, r_s2_py, r_s2_den;
    logic signed [FW-1:0] r_s2_tx, r_s2_ty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_s2_valid <= 1'b0;
        else          r_s2_valid <= r_s1_valid;
        r_s2_px  <= LW'(r_s1_p0) + LW'(r_s1_p1) + (LW'(m2) <<< 12);
        r_s2_py  <= LW'(r_s1_p3) + LW'(r_s1_p4) + (LW'(m5) <<< 12);
        r_s2_den <= LW'(r_s1_p6) + LW'(r_s1_p7) + (LW'(m8) <<< 12);
        r_s2_tx  <= r_s1_tx;
        r_s2_ty  <= r_s1_ty;
    end

    // stage 3: magnitudes, signs and zero denominator
    logic [LW-1:0] abs_px, abs_py, abs_den;
    assign abs_px  = r_s2_px[LW-1]  ? LW'(-r_s2_px)  : LW'(r_s2_px);
    assign abs_py  = r_s2_py[LW-1]  ? LW'(-r_s2_py)  : LW'(r_s2_py);
    assign abs_den = r_s2_den[LW-1] ? LW'(-r_s2_den) : LW'(r_s2_den);

    logic                 r_s3_valid, r_s3_dz, r_s3_negx, r_s3_negy;
    logic [MW-1:0]        r_s3_nx, r_s3_ny, r_s3_d;
    logic signed [LW-1:0] r_s3_px, r_s3_py;
    logic signed [FW-1:0] r_s3_tx, r_s3_ty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_s3_valid <= 1'b0;
        else          r_s3_valid <= r_s2_valid;
        r_s3_dz   <= (r_s2_den == '0);
        r_s3_negx <= r_s2_px[LW-1] ^ r_s2_den[LW-1];
        r_s3_negy <= r_s2_py[LW-1] ^ r_s2_den[LW-1];
        r_s3_nx   <= abs_px[MW-1:0];
        r_s3_ny   <= abs_py[MW-1:0];
        // a zero divisor is replaced; its result is overridden later
        r_s3_d    <= (r_s2_den == '0) ? MW'(1) : abs_den[MW-1:0];
        r_s3_px   <= r_s2_px;
        r_s3_py   <= r_s2_py;
        r_s3_tx   <= r_s2_tx;
        r_s3_ty   <= r_s2_ty;
    end

    // divider pipeline: lane 0 is loaded with the initial remainder
    tre_pkg::t_lane r_lx [0:DS];
    tre_pkg::t_lane r_ly [0:DS];
    tre_pkg::t_side r_side [0:DS];

    logic [MW-1:0] init_rx, init_ry;
    assign init_rx = r_s3_nx >> tre_pkg::NLO_W;
    assign init_ry = r_s3_ny >> tre_pkg::NLO_W;

    always_ff @(posedge i_clk) begin
        r_lx[0].rem <= init_rx;
        r_lx[0].den <= r_s3_d;
        r_lx[0].nn  <= {r_s3_nx[tre_pkg::NLO_W-1:0], (QW - tre_pkg::NLO_W)'(0)};
        r_lx[0].quo <= '0;
        r_lx[0].neg <= r_s3_negx;
        r_ly[0].rem <= init_ry;
        r_ly[0].den <= r_s3_d;
        r_ly[0].nn  <= {r_s3_ny[tre_pkg::NLO_W-1:0], (QW - tre_pkg::NLO_W)'(0)};
        r_ly[0].quo <= '0;
        r_ly[0].neg <= r_s3_negy;
        r_side[0].dz    <= r_s3_dz;
        r_side[0].ovf_x <= (init_rx >= r_s3_d);
        r_side[0].ovf_y <= (init_ry >= r_s3_d);
        r_side[0].px    <= r_s3_px;
        r_side[0].py    <= r_s3_py;
        r_side[0].tx    <= r_s3_tx;
        r_side[0].ty    <= r_s3_ty;
        if (!i_rst_n) r_side[0].valid <= 1'b0;
        else          r_side[0].valid <= r_s3_valid;
    end

    // advance each lane one quotient bit per stage; clear the side data in reset
    always_ff @(posedge i_clk) begin
        for (int k = 1; k <= DS; k++) begin
            r_lx[k]   <= tre_pkg::div_step(r_lx[k-1]);
            r_ly[k]   <= tre_pkg::div_step(r_ly[k-1]);
            r_side[k] <= i_rst_n ? r_side[k-1] : '0;
        end
    end

    // stage E1: mapped point and its difference to the target
    logic signed [LW-1:0] qx_s, qy_s, map_x, map_y;
    assign qx_s  = $signed({(LW - QW)'(0), r_lx[DS].quo});
    assign qy_s  = $signed({(LW - QW)'(0), r_ly[DS].quo});
    assign map_x = r_model_kind ? (r_lx[DS].neg ? -qx_s : qx_s) : r_side[DS].px;
    assign map_y = r_model_kind ? (r_ly[DS].neg ? -qy_s : qy_s) : r_side[DS].py;

    logic                 r_e1_valid, r_e1_dz, r_e1_sat;
    logic signed [LW:0]   r_e1_dx, r_e1_dy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_e1_valid <= 1'b0;
        else          r_e1_valid <= r_side[DS].valid;
        r_e1_dz  <= r_model_kind && r_side[DS].dz;
        r_e1_sat <= r_model_kind &&
                    (r_side[DS].dz || r_side[DS].ovf_x || r_side[DS].ovf_y);
        r_e1_dx  <= (LW+1)'(map_x) - ((LW+1)'(r_side[DS].tx) <<< 16);
        r_e1_dy  <= (LW+1)'(map_y) - ((LW+1)'(r_side[DS].ty) <<< 16);
    end

    // stage E2: magnitude of the error, range check
    logic [LW:0] mag_x, mag_y;
    assign mag_x = r_e1_dx[LW] ? (LW+1)'(-r_e1_dx) : (LW+1)'(r_e1_dx);
    assign mag_y = r_e1_dy[LW] ? (LW+1)'(-r_e1_dy) : (LW+1)'(r_e1_dy);

    logic           r_e2_valid, r_e2_dz, r_e2_sat;
    logic [SMW-1:0] r_e2_mx, r_e2_my;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_e2_valid <= 1'b0;
        else          r_e2_valid <= r_e1_valid;
        r_e2_dz  <= r_e1_dz;
        r_e2_sat <= r_e1_sat || (mag_x[LW:SMW] != '0) || (mag_y[LW:SMW] != '0);
        r_e2_mx  <= mag_x[SMW-1:0];
        r_e2_my  <= mag_y[SMW-1:0];
    end

    // stage E3: partial products of the squares
    logic           r_e3_valid, r_e3_dz, r_e3_sat;
    logic [SMW-1:0] r_e3_hhx, r_e3_hlx, r_e3_llx, r_e3_hhy, r_e3_hly, r_e3_lly;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_e3_valid <= 1'b0;
        else          r_e3_valid <= r_e2_valid;
        r_e3_dz  <= r_e2_dz;
        r_e3_sat <= r_e2_sat;
        r_e3_hhx <= r_e2_mx[SMW-1:HW] * r_e2_mx[SMW-1:HW];
        r_e3_hlx <= r_e2_mx[SMW-1:HW] * r_e2_mx[HW-1:0];
        r_e3_llx <= r_e2_mx[HW-1:0]   * r_e2_mx[HW-1:0];
        r_e3_hhy <= r_e2_my[SMW-1:HW] * r_e2_my[SMW-1:HW];
        r_e3_hly <= r_e2_my[SMW-1:HW] * r_e2_my[HW-1:0];
        r_e3_lly <= r_e2_my[HW-1:0]   * r_e2_my[HW-1:0];
    end

    // stage E4: assemble each square
    logic                       r_e4_valid, r_e4_dz, r_e4_sat;
    logic [tre_pkg::SQ_W-1:0]   r_e4_sqx, r_e4_sqy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_e4_valid <= 1'b0;
        else          r_e4_valid <= r_e3_valid;
        r_e4_dz  <= r_e3_dz;
        r_e4_sat <= r_e3_sat;
        r_e4_sqx <= (tre_pkg::SQ_W'(r_e3_hhx) << SMW) + (tre_pkg::SQ_W'(r_e3_hlx) << (HW + 1))
                    + tre_pkg::SQ_W'(r_e3_llx);
        r_e4_sqy <= (tre_pkg::SQ_W'(r_e3_hhy) << SMW) + (tre_pkg::SQ_W'(r_e3_hly) << (HW + 1))
                    + tre_pkg::SQ_W'(r_e3_lly);
    end

    // stage E5: round, saturate and present the result
    logic [tre_pkg::SUM_W-1:0] err_sum;
    assign err_sum = tre_pkg::SUM_W'(r_e4_sqx) + tre_pkg::SUM_W'(r_e4_sqy)
                   + (tre_pkg::SUM_W'(1) << 31);

    logic        r_done, r_dz_out;
    logic [63:0] r_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done   <= 1'b0;
            r_dz_out <= 1'b0;
        end else begin
            r_done   <= r_e4_valid;
            r_dz_out <= r_e4_valid && r_e4_dz;
        end
        if (r_e4_sat || (err_sum[tre_pkg::SUM_W-1:96] != '0)) r_err <= '1;
        else                                                 r_err <= err_sum[95:32];
    end

    assign o_done       = r_done;
    assign o_sq_error   = r_err;
    assign o_denom_zero = r_dz_out;

`ifndef SYNTHESIS
    a_latency : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##(tre_pkg::LATENCY) o_done)
        else $error("command transaction did not produce a result on time");
    a_dz_sat : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_denom_zero) |-> (o_sq_error == '1))
        else $error("zero denominator without saturated error");
    a_dz_strobe : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_denom_zero |-> o_done)
        else $error("denominator flag outside a result");
    a_no_phantom : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_side[DS].valid |=> ##4 o_done)
        else $error("divider output lost before the result");
`endif

endmodule

// File: bench/tre_checker.sv
// Checker for the reprojection error block: predicts every result and compares it on arrival.
module tre_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  logic [31:0] i_src_x,
    input  logic [31:0] i_src_y,
    input  logic [31:0] i_dst_x,
    input  logic [31:0] i_dst_y,
    input  logic        i_done,
    input  logic [63:0] i_sq_error,
    input  logic        i_denom_zero,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [tre_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [63:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_result_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [127:0] t_wide;

    typedef struct {
        logic [63:0] sq_error;
        logic        denom_zero;
    } t_err_result;

    // shadow copy of the configuration registers
    logic        model_kind;
    logic [63:0] pair_a, pair_b, pair_c, pair_d;
    logic [31:0] coef_m8;

    t_err_result expected_errors[$];

    assign o_pending = expected_errors.size();

    // sign extend a coordinate from its low COORD_WIDTH bits
    function automatic t_wide coord_value(input logic [31:0] v);
        logic signed [31:0] t;
        t = $signed(v << (32 - tre_pkg::COORD_WIDTH)) >>> (32 - tre_pkg::COORD_WIDTH);
        return t_wide'(t);
    endfunction

    function automatic t_wide coef_value(input logic [31:0] v);
        logic signed [31:0] t;
        t = $signed(v);
        return t_wide'(t);
    endfunction

    // ca*x + cb*y + cc, all in Q.28
    function automatic t_wide linear_q28(input logic [31:0] ca, input logic [31:0] cb,
                                         input logic [31:0] cc, input t_wide x,
                                         input t_wide y);
        return coef_value(ca) * x + coef_value(cb) * y + (coef_value(cc) <<< 12);
    endfunction

    function automatic t_wide magnitude(input t_wide v);
        return (v < 0) ? -v : v;
    endfunction

    // numerator * 2^28 / denominator, truncated toward zero
    function automatic t_wide project(input t_wide num, input t_wide den);
        logic  flip;
        t_wide q;
        flip = (num < 0) != (den < 0);
        q = t_wide'(unsigned'(magnitude(num) <<< 28) / unsigned'(magnitude(den)));
        return flip ? -q : q;
    endfunction

    function automatic t_err_result predict_error(input logic [31:0] sx, input logic [31:0] sy,
                                                  input logic [31:0] tx, input logic [31:0] ty);
        t_err_result r;
        t_wide x, y, px, py, den, dx, dy, sum;
        x = coord_value(sx);
        y = coord_value(sy);
        px = linear_q28(pair_a[31:0], pair_a[63:32], pair_b[31:0], x, y);
        py = linear_q28(pair_b[63:32], pair_c[31:0], pair_c[63:32], x, y);
        r.denom_zero = 1'b0;
        r.sq_error = '1;
        if (model_kind) begin
            den = linear_q28(pair_d[31:0], pair_d[63:32], coef_m8, x, y);
            if (den == 0) begin
                r.denom_zero = 1'b1;
                return r;
            end
            px = project(px, den);
            py = project(py, den);
        end
        dx = magnitude(px - (coord_value(tx) <<< 16));
        dy = magnitude(py - (coord_value(ty) <<< 16));
        if (dx >= (t_wide'(1) <<< 48) || dy >= (t_wide'(1) <<< 48))
            return r;
        sum = dx * dx + dy * dy + (t_wide'(1) <<< 31);
        if (sum[127:96] == 0)
            r.sq_error = sum[95:32];
        return r;
    endfunction

    // track configuration, queue predictions, compare results
    always @(posedge i_clk) begin
        t_err_result want;
        if (!i_rst_n) begin
            model_kind <= 1'b0;
            pair_a <= '0;
            pair_b <= '0;
            pair_c <= '0;
            pair_d <= '0;
            coef_m8 <= tre_pkg::COEF_ONE;
            expected_errors.delete();
            o_fail_count <= 0;
            o_result_count <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    tre_pkg::REG_MODEL_KIND:  model_kind <= i_cfg_data[0];
                    tre_pkg::REG_COEF_PAIR_A: pair_a <= i_cfg_data;
                    tre_pkg::REG_COEF_PAIR_B: pair_b <= i_cfg_data;
                    tre_pkg::REG_COEF_PAIR_C: pair_c <= i_cfg_data;
                    tre_pkg::REG_COEF_PAIR_D: pair_d <= i_cfg_data;
                    tre_pkg::REG_COEF_LAST:   coef_m8 <= i_cfg_data[31:0];
                    default: ;
                endcase
            end
            if (i_done) begin
                o_result_count <= o_result_count + 1;
                if (expected_errors.size() == 0) begin
                    $error("result with nothing expected: sq_error %h", i_sq_error);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_errors.pop_front();
                    if (want.sq_error !== i_sq_error || want.denom_zero !== i_denom_zero) begin
                        if (want.sq_error !== i_sq_error)
                            $error("sq_error: expected %h, actual %h",
                                   want.sq_error, i_sq_error);
                        if (want.denom_zero !== i_denom_zero)
                            $error("denom_zero: expected %b, actual %b",
                                   want.denom_zero, i_denom_zero);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_start && !i_busy)
                expected_errors.push_back(predict_error(i_src_x, i_src_y, i_dst_x, i_dst_y));
        end
    end
endmodule

// File: bench/tb_transform_reprojection_error_top.sv
// Testbench top: drives point pairs and configuration into the block and gives the verdict.
module tb_transform_reprojection_error_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 4000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_start = 1'b0;
    logic        o_busy;
    logic [31:0] i_src_x = '0, i_src_y = '0, i_dst_x = '0, i_dst_y = '0;
    logic        o_done;
    logic [63:0] o_sq_error;
    logic        o_denom_zero;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [tre_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [63:0] i_cfg_data = '0;

    int fail_count, pending, result_count;
    int items_sent = 0;
    int idle_cycles = 0;

    always #10 i_clk = ~i_clk;

    transform_reprojection_error_top dut (
        .i_clk, .i_rst_n, .i_start, .o_busy,
        .i_src_x, .i_src_y, .i_dst_x, .i_dst_y,
        .o_done, .o_sq_error, .o_denom_zero,
        .i_cfg_valid, .o_cfg_ready, .i_cfg_index, .i_cfg_data
    );

    tre_checker u_check (
        .i_clk, .i_rst_n, .i_start, .i_busy(o_busy),
        .i_src_x, .i_src_y, .i_dst_x, .i_dst_y,
        .i_done(o_done), .i_sq_error(o_sq_error), .i_denom_zero(o_denom_zero),
        .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_index, .i_cfg_data,
        .o_fail_count(fail_count), .o_pending(pending), .o_result_count(result_count)
    );

    // watchdog: end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_done || (i_cfg_valid && o_cfg_ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // present one register write and hold it until taken
    task automatic write_reg(input logic [tre_pkg::CFG_IDX_W-1:0] idx,
                             input logic [63:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // hold off until every result is in, then let the pipeline drain
    task automatic drain_pipeline();
        i_start <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (tre_pkg::LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic send_pair(input logic [31:0] sx, input logic [31:0] sy,
                             input logic [31:0] tx, input logic [31:0] ty);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 17) : 0;
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_src_x <= sx;
        i_src_y <= sy;
        i_dst_x <= tx;
        i_dst_y <= ty;
        do @(posedge i_clk); while (o_busy);
        items_sent++;
    endtask

    // load a whole model while the block is idle
    task automatic load_model(input logic kind, input logic [63:0] a, input logic [63:0] b,
                              input logic [63:0] c, input logic [63:0] d,
                              input logic [31:0] m8);
        drain_pipeline();
        write_reg(tre_pkg::REG_MODEL_KIND, {63'd0, kind});
        write_reg(tre_pkg::REG_COEF_PAIR_A, a);
        write_reg(tre_pkg::REG_COEF_PAIR_B, b);
        write_reg(tre_pkg::REG_COEF_PAIR_C, c);
        write_reg(tre_pkg::REG_COEF_PAIR_D, d);
        write_reg(tre_pkg::REG_COEF_LAST, {32'd0, m8});
        i_cfg_valid <= 1'b0;
    endtask

    // coefficient within about +-2.0, or full range now and then
    function automatic logic [31:0] rand_coef();
        if ($urandom_range(0, 7) == 0)
            return $urandom;
        return $urandom_range(0, 262144) - 131072;
    endfunction

    function automatic logic [31:0] rand_coord();
        if ($urandom_range(0, 7) == 0)
            return $urandom;
        if ($urandom_range(0, 9) == 0)
            return '0;
        return $urandom_range(0, 2097152) - 1048576;
    endfunction

    task automatic random_pairs(input int count);
        logic [31:0] sx, sy;
        for (int n = 0; n < count; n++) begin
            sx = rand_coord();
            sy = rand_coord();
            // targets near the source keep most errors out of saturation
            if ($urandom_range(0, 3) != 0)
                send_pair(sx, sy, sx + $urandom_range(0, 8191) - 4096,
                          sy + $urandom_range(0, 8191) - 4096);
            else
                send_pair(sx, sy, $urandom, $urandom);
            if (n == count / 2 && $urandom_range(0, 1) == 0)
                drain_pipeline();
        end
    endtask

    function automatic logic [63:0] rand_pair();
        return {rand_coef(), rand_coef()};
    endfunction

    localparam logic [31:0] MIN32 = 32'h8000_0000;
    localparam logic [31:0] MAX32 = 32'h7fff_ffff;
    localparam logic [63:0] IDENT_A = {32'd0, tre_pkg::COEF_ONE};
    localparam logic [63:0] IDENT_C = {32'd0, tre_pkg::COEF_ONE};

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset model: every point maps to the origin
        send_pair('0, '0, '0, '0);
        send_pair(MAX32, MIN32, 32'h0000_1000, 32'hffff_f000);
        send_pair('0, '0, MAX32, MAX32);
        send_pair('0, '0, MIN32, MIN32);

        // identity, affine
        load_model(1'b0, IDENT_A, '0, IDENT_C, '0, tre_pkg::COEF_ONE);
        send_pair(32'h0001_0000, 32'h0002_0000, 32'h0001_0000, 32'h0002_0000);
        send_pair(32'h0001_0000, 32'h0002_0000, 32'h0001_0001, 32'h0002_0000);
        send_pair(MAX32, MAX32, MIN32, MIN32);
        send_pair(32'hffff_ffff, 32'h1, '0, '0);

        // identity homography; a zero denominator from m6*x + m8
        load_model(1'b1, IDENT_A, '0, IDENT_C, {32'd0, tre_pkg::COEF_ONE}, '0);
        send_pair('0, 32'h0000_5000, '0, '0);
        send_pair(32'h0000_1000, 32'h0000_3000, 32'h0000_1000, 32'h0000_3000);
        send_pair(32'hffff_f000, 32'h0000_2000, MAX32, MIN32);

        // all-zero denominator
        load_model(1'b1, IDENT_A, '0, IDENT_C, '0, '0);
        send_pair(32'h0000_1000, 32'h0000_1000, '0, '0);

        // extreme coefficients
        load_model(1'b0, {MIN32, MIN32}, {MIN32, MIN32}, {MIN32, MIN32}, '1, MAX32);
        send_pair(MIN32, MIN32, MAX32, MAX32);
        send_pair(MAX32, MAX32, MIN32, MIN32);
        load_model(1'b1, {MAX32, MAX32}, {MAX32, MAX32}, {MAX32, MAX32},
                   {MIN32, MAX32}, MIN32);
        send_pair(MAX32, MIN32, '0, '0);
        send_pair(32'h1, 32'hffff_ffff, MAX32, MIN32);

        // random models, alternating between affine and homography
        for (int phase = 0; phase < 9; phase++) begin
            if (phase == 4)
                load_model(1'b0, IDENT_A, '0, IDENT_C, '0, tre_pkg::COEF_ONE);
            else if (phase == 7)
                load_model(1'b1, {rand_coef(), rand_coef()}, rand_pair(), rand_pair(),
                           {$urandom_range(0, 255) - 128, $urandom_range(0, 255) - 128},
                           tre_pkg::COEF_ONE);
            else
                load_model(phase[0], rand_pair(), rand_pair(), rand_pair(),
                           (phase == 2) ? 64'd0 : {32'($urandom_range(0, 4095)) - 2048,
                                                   32'($urandom_range(0, 4095)) - 2048},
                           (phase == 5) ? 32'd0 : rand_coef());
            random_pairs(200);
        end

        i_start <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (tre_pkg::LATENCY + 4) @(posedge i_clk);

        $display("Sent %0d point pairs under 15 models (affine and homography, extremes",
                 items_sent);
        $display("and zero denominators); %0d results compared", result_count);
        if (fail_count == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

// File: files.f
rtl/tre_pkg.sv
rtl/transform_reprojection_error_top.sv
bench/tre_checker.sv
bench/tb_transform_reprojection_error_top.sv
